/* sv/mtg_pkg.sv */
// mtg_pkg: shared types, constants and helpers for the MT19937 generator.
// No dependencies; used by mtg_front, mtg_engine and mt19937_generator.
package mtg_pkg;

  localparam int STATE_WORDS_DEF  = 624;
  localparam int SHIFT_OFFSET_DEF = 397;

  localparam logic [31:0] MUL_LINEAR  = 32'd1812433253;
  localparam logic [31:0] MUL_ARRAY1  = 32'd1664525;
  localparam logic [31:0] MUL_ARRAY2  = 32'd1566083941;
  localparam logic [31:0] ARRAY_SEED  = 32'd19650218;
  localparam logic [31:0] RESET_SEED  = 32'd5489;
  localparam logic [31:0] TWIST_MAT   = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B    = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C    = 32'hefc60000;
  localparam logic [31:0] UPPER_MASK  = 32'h80000000;
  localparam logic [31:0] LOWER_MASK  = 32'h7fffffff;

  localparam logic MODE_DRAW   = 1'b0;
  localparam logic MODE_RESEED = 1'b1;
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;
  localparam logic CFG_SEED_VALUE  = 1'b0;
  localparam logic CFG_SEED_METHOD = 1'b1;
  localparam logic METHOD_LINEAR = 1'b0;
  localparam logic METHOD_ARRAY  = 1'b1;

  typedef struct packed {
    logic       reseed;
    logic [5:0] bits;   // already clamped to 0..32
  } cmd_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] fold30(input logic [31:0] p);
    return p ^ (p >> 30);
  endfunction

endpackage

/* sv/mtg_front.sv */
// mtg_front: accepts input items, clamps the bit count and queues them.
// Two-entry queue decouples the input from the engine. Uses mtg_pkg.
module mtg_front import mtg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [5:0] in_bits,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c_new;
  logic       push;

  always_comb begin
    c_new.reseed = (in_mode == MODE_RESEED);
    c_new.bits   = (in_bits > 6'd32) ? 6'd32 : in_bits;
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wp_r] <= c_new;
        wp_r      <= ~wp_r;
      end
      if (cmd_pop && cmd_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, cmd_pop && cmd_valid};
    end
  end

endmodule

/* sv/mtg_engine.sv */
// mtg_engine: state memory, seeding sequencer, on-the-fly twist and tempering.
// Holds the output register. Uses mtg_pkg.
module mtg_engine import mtg_pkg::*; #(
  parameter int STATE_WORDS  = STATE_WORDS_DEF,
  parameter int SHIFT_OFFSET = SHIFT_OFFSET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  logic [63:0] seed_value,
  input  logic        seed_method,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic        out_kind
);

  localparam int AW = $clog2(STATE_WORDS);
  localparam logic [AW-1:0] LAST  = AW'(STATE_WORDS - 1);
  localparam logic [AW-1:0] OFS   = AW'(SHIFT_OFFSET);
  localparam logic [AW-1:0] WRAPB = AW'(STATE_WORDS - SHIFT_OFFSET);

  typedef enum logic [3:0] {
    S_IDLE, S_LIN0, S_LIN_MUL, S_LIN_WR, S_A_MUL, S_A_WR, S_WRAP, S_FIX,
    S_D_RD1, S_D_RD2, S_D_WR, S_FIN
  } state_t;

  logic [31:0] mem [STATE_WORDS];

  state_t      state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt, pos_r, pos_nxt, cnt_r, cnt_nxt;
  logic        j_r, j_nxt, arr_r, arr_nxt, ph2_r, ph2_nxt, boot_r, boot_nxt;
  logic [31:0] prev_r, prev_nxt, prod_r, prod_nxt, w_r, w_nxt;
  logic [31:0] res_r, res_nxt;
  logic        kind_r, kind_nxt;
  logic [5:0]  bits_r, bits_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] ov_val_r, ov_val_nxt;
  logic        ov_kind_r, ov_kind_nxt;

  logic [AW-1:0] ra_addr, rb_addr, wa;
  logic [31:0]   ra_q_r, rb_q_r, wd, nv, key, tw, tmp;
  logic          we;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    ra_q_r <= mem[ra_addr];
    rb_q_r <= mem[rb_addr];
  end

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; pos_nxt = pos_r; cnt_nxt = cnt_r;
    j_nxt = j_r; arr_nxt = arr_r; ph2_nxt = ph2_r; boot_nxt = boot_r;
    prev_nxt = prev_r; prod_nxt = prod_r; w_nxt = w_r; res_nxt = res_r;
    kind_nxt = kind_r; bits_nxt = bits_r;
    ov_nxt = ov_r && out_stall; ov_val_nxt = ov_val_r; ov_kind_nxt = ov_kind_r;
    cmd_pop = 1'b0; we = 1'b0; wa = idx_r; wd = prev_r;
    ra_addr = idx_r; rb_addr = idx_r; nv = '0; tw = '0; tmp = '0;
    key = j_r ? seed_value[31:0] : seed_value[63:32];
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          bits_nxt = cmd.bits;
          if (cmd.reseed) begin
            arr_nxt   = (seed_method == METHOD_ARRAY);
            prev_nxt  = (seed_method == METHOD_ARRAY) ? ARRAY_SEED : seed_value[31:0];
            state_nxt = S_LIN0;
          end else begin
            state_nxt = S_D_RD1;
          end
        end
      end
      S_LIN0: begin
        we = 1'b1; wa = '0; wd = prev_r;
        idx_nxt = AW'(1); state_nxt = S_LIN_MUL;
      end
      S_LIN_MUL: begin
        prod_nxt = MUL_LINEAR * fold30(prev_r);
        state_nxt = S_LIN_WR;
      end
      S_LIN_WR: begin
        nv = prod_r + 32'(idx_r);
        we = 1'b1; wd = nv; prev_nxt = nv;
        if (idx_r == LAST) begin
          pos_nxt = '0;
          if (arr_r) begin
            // array pass starts at word 1, whose predecessor is the seed word
            idx_nxt = AW'(1); j_nxt = 1'b0; ph2_nxt = 1'b0;
            prev_nxt = ARRAY_SEED;
            cnt_nxt = AW'(STATE_WORDS);
            state_nxt = S_A_MUL;
          end else if (boot_r) begin
            boot_nxt = 1'b0; state_nxt = S_IDLE;
          end else begin
            res_nxt = '0; kind_nxt = KIND_RESEED; state_nxt = S_FIN;
          end
        end else begin
          idx_nxt = idx_r + AW'(1); state_nxt = S_LIN_MUL;
        end
      end
      S_A_MUL: begin
        prod_nxt = (ph2_r ? MUL_ARRAY2 : MUL_ARRAY1) * fold30(prev_r);
        ra_addr = idx_r;
        state_nxt = S_A_WR;
      end
      S_A_WR: begin
        tmp = ra_q_r ^ prod_r;
        nv  = ph2_r ? (tmp - 32'(idx_r)) : (tmp + key + {31'd0, j_r});
        we = 1'b1; wd = nv; prev_nxt = nv;
        j_nxt = ~j_r;
        cnt_nxt = cnt_r - AW'(1);
        if (idx_r == LAST) begin
          state_nxt = S_WRAP;
        end else begin
          idx_nxt = idx_r + AW'(1);
          if (cnt_r == AW'(1)) begin
            if (ph2_r) state_nxt = S_FIX;
            else begin
              ph2_nxt = 1'b1; cnt_nxt = LAST; state_nxt = S_A_MUL;
            end
          end else begin
            state_nxt = S_A_MUL;
          end
        end
      end
      S_WRAP: begin
        // word 0 takes a copy of the last word
        we = 1'b1; wa = '0; wd = prev_r; idx_nxt = AW'(1);
        if (cnt_r == '0) begin
          if (ph2_r) state_nxt = S_FIX;
          else begin
            ph2_nxt = 1'b1; cnt_nxt = LAST; state_nxt = S_A_MUL;
          end
        end else begin
          state_nxt = S_A_MUL;
        end
      end
      S_FIX: begin
        we = 1'b1; wa = '0; wd = UPPER_MASK;
        res_nxt = '0; kind_nxt = KIND_RESEED; state_nxt = S_FIN;
      end
      S_D_RD1: begin
        ra_addr = pos_r;
        rb_addr = (pos_r == LAST) ? '0 : pos_r + AW'(1);
        state_nxt = S_D_RD2;
      end
      S_D_RD2: begin
        ra_addr = (pos_r >= WRAPB) ? pos_r - WRAPB : pos_r + OFS;
        w_nxt = (ra_q_r & UPPER_MASK) | (rb_q_r & LOWER_MASK);
        state_nxt = S_D_WR;
      end
      S_D_WR: begin
        nv = ra_q_r ^ (w_r >> 1) ^ (w_r[0] ? TWIST_MAT : 32'd0);
        we = 1'b1; wa = pos_r; wd = nv;
        pos_nxt = (pos_r == LAST) ? '0 : pos_r + AW'(1);
        tw = temper(nv);
        res_nxt = (bits_r == 6'd0) ? 32'd0 : (tw >> (6'd32 - bits_r));
        kind_nxt = KIND_DRAW; state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1; ov_val_nxt = res_r; ov_kind_nxt = kind_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LIN0;
      boot_r  <= 1'b1;
      arr_r   <= 1'b0;
      prev_r  <= RESET_SEED;
      pos_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      boot_r  <= boot_nxt;
      arr_r   <= arr_nxt;
      prev_r  <= prev_nxt;
      pos_r   <= pos_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r <= idx_nxt; cnt_r <= cnt_nxt; j_r <= j_nxt; ph2_r <= ph2_nxt;
    prod_r <= prod_nxt; w_r <= w_nxt; res_r <= res_nxt; kind_r <= kind_nxt;
    bits_r <= bits_nxt; ov_val_r <= ov_val_nxt; ov_kind_r <= ov_kind_nxt;
  end

  assign out_valid = ov_r;
  assign out_value = ov_val_r;
  assign out_kind  = ov_kind_r;

endmodule

/* sv/mt19937_generator.sv */
// mt19937_generator: top level of the MT19937 random generator.
// Instantiates mtg_front and mtg_engine; holds the seed registers. Uses mtg_pkg.
//
//  port group | direction | handshake          | payload
//  in_*       | input     | in_valid/in_stall   | in_mode, in_bits
//  out_*      | output    | out_valid/out_stall | out_value, out_kind
//  cfg_*      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A draw passes through the engine steps pop, two memory read steps, twist and
// write, and result load; the registered reads of the state memory set these steps.
// A linear reseed takes a multiply and a write step for each state word after
// word 0; an array reseed adds two more passes of such steps over the words.
// After reset the engine runs the linear init from 5489 before taking items; up to two items queue in the meantime.
// The result register lets the engine finish one more item under out_stall.
module mt19937_generator import mtg_pkg::*; #(
  parameter int STATE_WORDS  = STATE_WORDS_DEF,
  parameter int SHIFT_OFFSET = SHIFT_OFFSET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [5:0]  in_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic        out_kind,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] seed_value_r;
  logic        seed_method_r;
  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_value_r  <= {32'd0, RESET_SEED};
      seed_method_r <= METHOD_LINEAR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEED_VALUE:  seed_value_r  <= cfg_data;
        CFG_SEED_METHOD: seed_method_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mtg_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_bits(in_bits),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  mtg_engine #(
    .STATE_WORDS(STATE_WORDS), .SHIFT_OFFSET(SHIFT_OFFSET)
  ) u_engine (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .seed_value(seed_value_r), .seed_method(seed_method_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_kind(out_kind)
  );

endmodule

/* tb/tb_mt19937_generator.sv */
// tb_mt19937_generator: self-checking bench for the MT19937 generator.
// Drives draw and reseed transfers, writes the seed registers between phases and
// checks every result against an internal twister model. Needs mtg_pkg and the RTL.
module tb_mt19937_generator;
  import mtg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWORDS = 624;
  localparam int OFFSET = 397;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [5:0]  in_bits;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_value;
  logic        out_kind;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [63:0] cfg_data;

  mt19937_generator uut (.*);

  typedef struct {
    logic [31:0] value;
    logic        kind;
  } draw_result_t;

  typedef struct {
    logic        mode;
    logic [5:0]  bits;
    bit          typed;
    logic [31:0] value;
    logic        kind;
  } stim_row_t;

  // twister model
  logic [31:0]  mt_words [NWORDS];
  int unsigned  mt_pos;
  logic [63:0]  seed_reg;
  logic         method_reg;
  draw_result_t pending_results[$];
  int           errors;
  int           sender_idle;
  int           receiver_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void seed_linear(logic [31:0] s);
    logic [31:0] p;
    mt_words[0] = s;
    for (int i = 1; i < NWORDS; i++) begin
      p = mt_words[i-1];
      mt_words[i] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(i);
    end
    mt_pos = NWORDS;
  endfunction

  function automatic void seed_array(logic [31:0] key_hi, logic [31:0] key_lo);
    logic [31:0] key [2];
    logic [31:0] p;
    int i;
    int j;
    key[0] = key_hi;
    key[1] = key_lo;
    i = 1;
    j = 0;
    seed_linear(32'd19650218);
    for (int k = NWORDS; k != 0; k--) begin
      p = mt_words[i-1];
      mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * 32'd1664525)) + key[j] + 32'(j);
      i++;
      j++;
      if (i >= NWORDS) begin
        mt_words[0] = mt_words[NWORDS-1];
        i = 1;
      end
      if (j >= 2) j = 0;
    end
    for (int k = NWORDS - 1; k != 0; k--) begin
      p = mt_words[i-1];
      mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * 32'd1566083941)) - 32'(i);
      i++;
      if (i >= NWORDS) begin
        mt_words[0] = mt_words[NWORDS-1];
        i = 1;
      end
    end
    mt_words[0] = 32'h80000000;
    mt_pos = NWORDS;
  endfunction

  function automatic void twist_all();
    logic [31:0] y;
    for (int k = 0; k < NWORDS; k++) begin
      y = (mt_words[k] & 32'h80000000) | (mt_words[(k+1) % NWORDS] & 32'h7fffffff);
      mt_words[k] = mt_words[(k+OFFSET) % NWORDS] ^ (y >> 1) ^ (y[0] ? 32'h9908b0df : 32'h0);
    end
    mt_pos = 0;
  endfunction

  function automatic draw_result_t predict_draw(logic mode, logic [5:0] bits);
    draw_result_t r;
    logic [31:0] y;
    int unsigned n;
    if (mode == MODE_RESEED) begin
      if (method_reg == METHOD_LINEAR) seed_linear(seed_reg[31:0]);
      else seed_array(seed_reg[63:32], seed_reg[31:0]);
      r.value = '0;
      r.kind = KIND_RESEED;
      return r;
    end
    if (mt_pos >= NWORDS) twist_all();
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    n = (bits > 32) ? 32 : bits;
    r.value = (n == 0) ? 32'h0 : (y >> (32 - n));
    r.kind = KIND_DRAW;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    draw_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_value, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value) report_mismatch("value", out_value, want.value);
        if (out_kind !== want.kind) report_mismatch("kind", 32'(out_kind), 32'(want.kind));
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle);
  end

  // one input transfer; typed rows override the model's expectation.
  // in_valid stays high on return; callers drop it before waiting.
  task automatic send_item(logic mode, logic [5:0] bits, bit typed = 0,
                           logic [31:0] tv = '0, logic tk = 1'b0);
    draw_result_t r;
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_bits  <= bits;
    do @(posedge clk); while (!(in_valid && !in_stall));
    r = predict_draw(mode, bits);
    if (typed) begin
      if (r.value !== tv || r.kind !== tk) report_mismatch("typed row vs model", tv, r.value);
      r.value = tv;
      r.kind = tk;
    end
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SEED_VALUE) seed_reg = data;
    else method_reg = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_phase(int count, bit hold_off);
    logic [5:0] b;
    send_item(MODE_RESEED, 6'd0);
    for (int n = 0; n < count; n++) begin
      if (hold_off && n == count / 2) begin
        // let the pipeline empty completely before the next transfer
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      if ($urandom_range(99) < 3) begin
        send_item(MODE_RESEED, 6'($urandom));
      end else begin
        b = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(32, 1));
        send_item(MODE_DRAW, b);
      end
    end
    drain();
  endtask

  stim_row_t directed [] = '{
    '{MODE_DRAW,   6'd32, 1, 32'hd091bb5c, KIND_DRAW},
    '{MODE_DRAW,   6'd0,  1, 32'h0,        KIND_DRAW},
    '{MODE_DRAW,   6'd1,  0, 32'h0,        KIND_DRAW},
    '{MODE_DRAW,   6'd63, 0, 32'h0,        KIND_DRAW},
    '{MODE_DRAW,   6'd33, 0, 32'h0,        KIND_DRAW},
    '{MODE_DRAW,   6'd31, 0, 32'h0,        KIND_DRAW},
    '{MODE_RESEED, 6'd21, 1, 32'h0,        KIND_RESEED},
    '{MODE_DRAW,   6'd32, 1, 32'hd091bb5c, KIND_DRAW},
    '{MODE_DRAW,   6'd16, 1, 32'h000022ae, KIND_DRAW},
    '{MODE_DRAW,   6'd42, 0, 32'h0,        KIND_DRAW},
    '{MODE_DRAW,   6'd2,  0, 32'h0,        KIND_DRAW},
    '{MODE_DRAW,   6'd8,  0, 32'h0,        KIND_DRAW}
  };

  initial begin
    errors = 0;
    sender_idle = 22;
    receiver_idle = 47;
    seed_reg = 64'd5489;
    method_reg = METHOD_LINEAR;
    seed_linear(32'd5489);
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_DRAW;
    in_bits = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SEED_VALUE;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      send_item(directed[i].mode, directed[i].bits, directed[i].typed,
                directed[i].value, directed[i].kind);
    drain();

    write_reg(CFG_SEED_VALUE, 64'hffff_ffff_ffff_ffff);
    write_reg(CFG_SEED_METHOD, 64'(METHOD_ARRAY));
    random_phase(260, 0);

    sender_idle = 47;
    receiver_idle = 22;
    write_reg(CFG_SEED_VALUE, 64'h0);
    write_reg(CFG_SEED_METHOD, 64'(METHOD_LINEAR));
    random_phase(260, 1);

    sender_idle = 0;
    receiver_idle = 0;
    write_reg(CFG_SEED_VALUE, {$urandom, $urandom});
    write_reg(CFG_SEED_METHOD, 64'hffff_ffff_ffff_fffe);
    write_reg(CFG_SEED_METHOD, {$urandom, $urandom} | 64'h1);
    random_phase(260, 0);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
